// ===== src/blpel_pkg.sv =====
// ----------------------------------------------------------------------------
// blpel_pkg
// Shared types, codes and helper functions of the button long-press event
// latch.
// ----------------------------------------------------------------------------
package blpel_pkg;

  localparam int unsigned TICKS_W = 16;

  // request codes
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_TAKE_BACK  = 2'd1;
  localparam logic [1:0] REQ_TAKE_UI    = 2'd2;
  localparam logic [1:0] REQ_DISCARD_UI = 2'd3;

  // button codes
  localparam logic [2:0] BTN_NONE = 3'd0;
  localparam logic [2:0] BTN_BACK = 3'd1;
  localparam logic [2:0] BTN_MENU = 3'd2;
  localparam logic [2:0] BTN_UP   = 3'd3;
  localparam logic [2:0] BTN_DOWN = 3'd4;

  // event codes
  localparam logic [3:0] EV_NONE  = 4'd0;
  localparam logic [3:0] EV_BACK  = 4'd1;
  localparam logic [3:0] EV_MENU  = 4'd2;
  localparam logic [3:0] EV_UP    = 4'd3;
  localparam logic [3:0] EV_DOWN  = 4'd4;
  localparam logic [3:0] EV_LBACK = 4'd5;
  localparam logic [3:0] EV_LMENU = 4'd6;
  localparam logic [3:0] EV_LUP   = 4'd7;
  localparam logic [3:0] EV_LDOWN = 4'd8;

  // configuration register indexes
  localparam logic CFG_LONG_PRESS_TICKS = 1'b0;
  localparam logic CFG_PRESSED_LEVEL    = 1'b1;

  localparam logic [TICKS_W-1:0] LONG_PRESS_TICKS_RST = TICKS_W'(50);
  localparam logic               PRESSED_LEVEL_RST    = 1'b1;
  localparam logic [TICKS_W-1:0] HOLD_MAX             = '1;

  typedef enum logic [1:0] {
    PH_WAIT_ALL = 2'd0,
    PH_IDLE     = 2'd1,
    PH_TIMING   = 2'd2,
    PH_WAIT_REL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] pin_levels;
    logic [2:0] irq_button;
  } req_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic       latched_now;
    logic       is_long;
  } res_t;

  function automatic logic is_back(logic [3:0] ev);
    return (ev == EV_BACK) || (ev == EV_LBACK);
  endfunction

  // priority guard of a pending button against the latched event
  function automatic logic guard_ok(logic [2:0] btn, logic [3:0] ev);
    logic ok;
    ok = 1'b0;
    case (btn)
      BTN_BACK: ok = (ev != EV_LBACK);
      BTN_MENU: ok = !(ev inside {EV_BACK, EV_LBACK, EV_LMENU});
      BTN_UP:   ok = !(ev inside {EV_MENU, EV_BACK, EV_LBACK, EV_LMENU, EV_LUP});
      BTN_DOWN: ok = (ev == EV_NONE) || (ev == EV_DOWN);
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== src/blpel_req_if.sv =====
// ----------------------------------------------------------------------------
// blpel_req_if
// Request channel: ticks and consume requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface blpel_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] pin_levels;
  logic [2:0] irq_button;

  modport source (output valid, req_type, pin_levels, irq_button, input ready);
  modport sink   (input valid, req_type, pin_levels, irq_button, output ready);
endinterface

// ===== src/blpel_res_if.sv =====
// ----------------------------------------------------------------------------
// blpel_res_if
// Result channel: one result beat per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface blpel_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic       latched_now;
  logic       is_long;

  modport source (output valid, event_code, latched_now, is_long, input ready);
  modport sink   (input valid, event_code, latched_now, is_long, output ready);
endinterface

// ===== src/blpel_in_stage.sv =====
// ----------------------------------------------------------------------------
// blpel_in_stage
// Input register: holds one request beat until the core takes it.
// ----------------------------------------------------------------------------
module blpel_in_stage
  import blpel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  blpel_req_if.sink   req,
  input  logic        advance,
  output logic        item_valid,
  output req_t        item
);

  logic accept;

  assign req.ready = !item_valid || advance;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.req_type   <= req.req_type;
      item.pin_levels <= req.pin_levels;
      item.irq_button <= req.irq_button;
    end
  end

endmodule

// ===== src/blpel_core.sv =====
// ----------------------------------------------------------------------------
// blpel_core
// Configuration registers, qualifier state and the single-pass step logic.
// ----------------------------------------------------------------------------
module blpel_core
  import blpel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TICKS_W-1:0] cfg_data,
  input  logic               fire,
  input  req_t               item,
  output res_t               result
);

  logic [TICKS_W-1:0] long_press_ticks;
  logic               pressed_level;

  phase_t             phase, phase_next;
  logic [3:0]         latched_event, latched_event_next;
  logic [2:0]         pending_button, pending_button_next;
  logic [1:0]         active_button, active_button_next;
  logic [TICKS_W-1:0] hold_count, hold_count_next;

  logic [2:0]         irq_eff;
  logic [2:0]         pending_eff;
  logic [3:0]         pressed;
  logic               any_pressed;
  logic               active_pressed;
  logic [TICKS_W-1:0] hold_inc;
  logic               reach_long;
  logic               start_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_TICKS_RST;
      pressed_level    <= PRESSED_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        CFG_PRESSED_LEVEL:    pressed_level    <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  assign irq_eff        = (item.irq_button > BTN_DOWN) ? BTN_NONE : item.irq_button;
  assign pending_eff    = (irq_eff != BTN_NONE) ? irq_eff : pending_button;
  assign pressed        = ~(item.pin_levels ^ {4{pressed_level}});
  assign any_pressed    = |pressed;
  assign active_pressed = pressed[active_button];
  assign hold_inc       = (hold_count == HOLD_MAX) ? hold_count : hold_count + 1'b1;
  assign reach_long     = (hold_inc >= long_press_ticks);
  assign start_ok       = (pending_eff != BTN_NONE) && guard_ok(pending_eff, latched_event);

  // next phase
  always_comb begin
    phase_next = phase;
    if (item.req_type == REQ_TICK) begin
      unique case (phase)
        PH_WAIT_ALL: if (!any_pressed) phase_next = PH_IDLE;
        PH_IDLE:     if (start_ok) phase_next = PH_TIMING;
        PH_TIMING: begin
          if (!active_pressed) begin
            phase_next = PH_IDLE;
          end else if (reach_long) begin
            phase_next = PH_WAIT_REL;
          end
        end
        PH_WAIT_REL: if (!active_pressed) phase_next = PH_IDLE;
        default:     phase_next = PH_WAIT_ALL;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    latched_event_next  = latched_event;
    pending_button_next = pending_button;
    active_button_next  = active_button;
    hold_count_next     = hold_count;
    result              = '0;
    unique case (item.req_type)
      REQ_TAKE_BACK: begin
        if (is_back(latched_event)) begin
          result.event_code  = latched_event;
          latched_event_next = EV_NONE;
        end
      end
      REQ_TAKE_UI: begin
        if (!is_back(latched_event)) begin
          result.event_code  = latched_event;
          latched_event_next = EV_NONE;
        end
      end
      REQ_DISCARD_UI: begin
        if (!is_back(latched_event)) latched_event_next = EV_NONE;
      end
      default: begin
        unique case (phase)
          PH_WAIT_ALL: if (!any_pressed) pending_button_next = BTN_NONE;
          PH_IDLE: begin
            pending_button_next = BTN_NONE;
            if (start_ok) begin
              active_button_next = 2'(pending_eff - 3'd1);
              hold_count_next    = '0;
            end
          end
          PH_TIMING: begin
            pending_button_next = pending_eff;
            if (active_pressed) begin
              hold_count_next = hold_inc;
              if (reach_long) begin
                latched_event_next = EV_LBACK + {2'b00, active_button};
                result.event_code  = EV_LBACK + {2'b00, active_button};
                result.latched_now = 1'b1;
                result.is_long     = 1'b1;
              end
            end else begin
              latched_event_next = EV_BACK + {2'b00, active_button};
              result.event_code  = EV_BACK + {2'b00, active_button};
              result.latched_now = 1'b1;
            end
          end
          default: pending_button_next = pending_eff;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT_ALL;
      latched_event  <= EV_NONE;
      pending_button <= BTN_NONE;
      active_button  <= '0;
      hold_count     <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      latched_event  <= latched_event_next;
      pending_button <= pending_button_next;
      active_button  <= active_button_next;
      hold_count     <= hold_count_next;
    end
  end

endmodule

// ===== src/blpel_out_stage.sv =====
// ----------------------------------------------------------------------------
// blpel_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module blpel_out_stage
  import blpel_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  res_t          res_d,
  output logic          space,
  blpel_res_if.source   res
);

  logic valid;
  res_t data;

  assign space = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_d;
    end
  end

  assign res.valid       = valid;
  assign res.event_code  = data.event_code;
  assign res.latched_now = data.latched_now;
  assign res.is_long     = data.is_long;

endmodule

// ===== src/button_long_press_event_latch_unit.sv =====
// ----------------------------------------------------------------------------
// button_long_press_event_latch_unit
// Four-button keypad qualifier with long-press detection and event latch.
//
// req channel: one beat per tick (pin levels and interrupting button) or per
// consume request (take_back, take_ui, discard_ui). res channel: exactly one
// beat per request beat, in order, with the event code and latch flags.
// cfg port: cfg_we/cfg_index/cfg_data write long_press_ticks (index 0) and
// pressed_level (index 1); write only while no beat is in flight.
// Path from req beat to res valid: input register, then the step logic that
// updates the qualifier state and loads the result register together.
// Throughput is one beat per cycle while the receiver keeps taking results.
// A stalled receiver holds the result register; the input register keeps
// one more beat, after which req.ready drops until the result is taken.
// Reset: thresholds return to 50 ticks and active-high pins, the latch is
// empty and the block waits for all buttons released before timing.
// ----------------------------------------------------------------------------
module button_long_press_event_latch_unit
  import blpel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TICKS_W-1:0] cfg_data,
  blpel_req_if.sink          req,
  blpel_res_if.source        res
);

  logic item_valid;
  req_t item;
  res_t step_res;
  logic space;
  logic advance;

  assign advance = item_valid && space;

  blpel_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  blpel_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (step_res)
  );

  blpel_out_stage u_out_stage (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .res_d (step_res),
    .space (space),
    .res   (res)
  );

endmodule

// ===== tb/blpel_checker.sv =====
// ----------------------------------------------------------------------------
// blpel_checker
// Watches the request, result and configuration ports of the button
// long-press event latch, keeps its own model of the keypad qualifier and
// compares every result beat field by field against the expected queue.
// ----------------------------------------------------------------------------
module blpel_checker
  import blpel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TICKS_W-1:0] cfg_data,
  blpel_req_if               req,
  blpel_res_if               res,
  output int                 errors,
  output int                 pending
);

  logic [TICKS_W-1:0] hold_thr;
  logic               press_lvl;
  logic [3:0]         latch_ev;
  logic [2:0]         queued_btn;
  phase_t             ph;
  logic [1:0]         timed_btn;
  logic [TICKS_W-1:0] hold_cnt;
  res_t               event_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic back_kind(logic [3:0] ev);
    return (ev == EV_BACK) || (ev == EV_LBACK);
  endfunction

  // whether a pending button may start timing given the latched event
  function automatic logic may_start(logic [2:0] btn, logic [3:0] ev);
    case (btn)
      BTN_BACK: return ev != EV_LBACK;
      BTN_MENU: return !(ev inside {EV_BACK, EV_LBACK, EV_LMENU});
      BTN_UP:   return !(ev inside {EV_BACK, EV_MENU, EV_LBACK, EV_LMENU, EV_LUP});
      BTN_DOWN: return ev inside {EV_NONE, EV_DOWN};
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic is_down(logic [3:0] pins, logic [1:0] idx);
    return pins[idx] == press_lvl;
  endfunction

  function automatic res_t qualify(req_t r);
    res_t       o;
    logic [2:0] irq;
    o   = '0;
    irq = (r.irq_button > BTN_DOWN) ? BTN_NONE : r.irq_button;
    case (r.req_type)
      REQ_TAKE_BACK: begin
        if (back_kind(latch_ev)) begin
          o.event_code = latch_ev;
          latch_ev     = EV_NONE;
        end
      end
      REQ_TAKE_UI: begin
        if (!back_kind(latch_ev)) begin
          o.event_code = latch_ev;
          latch_ev     = EV_NONE;
        end
      end
      REQ_DISCARD_UI: begin
        if (!back_kind(latch_ev)) latch_ev = EV_NONE;
      end
      default: begin
        if (ph == PH_WAIT_ALL) begin
          if (r.pin_levels == {4{~press_lvl}}) begin
            queued_btn = BTN_NONE;
            ph         = PH_IDLE;
          end
        end else begin
          if (irq != BTN_NONE) queued_btn = irq;
          case (ph)
            PH_IDLE: begin
              if (queued_btn != BTN_NONE) begin
                if (may_start(queued_btn, latch_ev)) begin
                  timed_btn = 2'(queued_btn - 3'd1);
                  hold_cnt  = '0;
                  ph        = PH_TIMING;
                end
                queued_btn = BTN_NONE;
              end
            end
            PH_TIMING: begin
              if (is_down(r.pin_levels, timed_btn)) begin
                if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
                if (hold_cnt >= hold_thr) begin
                  latch_ev      = EV_LBACK + 4'(timed_btn);
                  o.event_code  = latch_ev;
                  o.latched_now = 1'b1;
                  o.is_long     = 1'b1;
                  ph            = PH_WAIT_REL;
                end
              end else begin
                latch_ev      = EV_BACK + 4'(timed_btn);
                o.event_code  = latch_ev;
                o.latched_now = 1'b1;
                ph            = PH_IDLE;
              end
            end
            default: begin
              if (!is_down(r.pin_levels, timed_btn)) ph = PH_IDLE;
            end
          endcase
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    req_t beat;
    if (rst) begin
      hold_thr   = LONG_PRESS_TICKS_RST;
      press_lvl  = PRESSED_LEVEL_RST;
      latch_ev   = EV_NONE;
      queued_btn = BTN_NONE;
      ph         = PH_WAIT_ALL;
      timed_btn  = '0;
      hold_cnt   = '0;
      event_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LONG_PRESS_TICKS) hold_thr = cfg_data;
        else press_lvl = cfg_data[0];
      end
      if (res.valid && res.ready) begin
        got.event_code  = res.event_code;
        got.latched_now = res.latched_now;
        got.is_long     = res.is_long;
        if (event_q.size() == 0) begin
          errors++;
          $error("unexpected result beat: event_code %0d latched_now %0b is_long %0b",
                 got.event_code, got.latched_now, got.is_long);
        end else begin
          want = event_q.pop_front();
          if (got.event_code !== want.event_code) begin
            errors++;
            $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
          end
          if (got.latched_now !== want.latched_now) begin
            errors++;
            $error("latched_now: expected %0b, got %0b", want.latched_now, got.latched_now);
          end
          if (got.is_long !== want.is_long) begin
            errors++;
            $error("is_long: expected %0b, got %0b", want.is_long, got.is_long);
          end
        end
      end
      if (req.valid && req.ready) begin
        beat.req_type   = req.req_type;
        beat.pin_levels = req.pin_levels;
        beat.irq_button = req.irq_button;
        event_q.push_back(qualify(beat));
      end
    end
    pending = event_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top of the button long-press event latch: clock, reset, a
// directed opening, then random press sequences, consume requests and noise
// under several thresholds and pin polarities, with random gaps and stalls
// on both channels and one long result-side hold-off. The checker does the
// prediction and comparison; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import blpel_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [TICKS_W-1:0] cfg_data;
  int                 errors;
  int                 pending;
  int                 beats_sent;
  int                 thr_now;
  logic               cur_level;
  logic               calm_tx;

  blpel_req_if req_ch ();
  blpel_res_if res_ch ();

  button_long_press_event_latch_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  blpel_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    cyc = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 600 && cyc < 800) res_ch.ready = 1'b0;
      else if (cyc >= 1500 && cyc < 2500) res_ch.ready = 1'b1;
      else res_ch.ready = ($urandom_range(99) >= 22);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [3:0] pins_with(logic [3:0] pressed_mask);
    return cur_level ? pressed_mask : ~pressed_mask;
  endfunction

  function automatic logic [1:0] pick_consume();
    case ($urandom_range(4))
      0, 1:    return REQ_TAKE_UI;
      2, 3:    return REQ_TAKE_BACK;
      default: return REQ_DISCARD_UI;
    endcase
  endfunction

  function automatic int pick_hold();
    int base;
    base = (thr_now > 60) ? 60 : thr_now;
    case ($urandom_range(3))
      0:       return $urandom_range(0, 3);
      1:       return base - 1 + $urandom_range(0, 2);
      default: return $urandom_range(0, base + 2);
    endcase
  endfunction

  function automatic logic [3:0] stray_pins();
    return ($urandom_range(99) < 25) ? 4'($urandom) : 4'b0000;
  endfunction

  task automatic offer_beat(logic [1:0] rq, logic [3:0] pins, logic [2:0] irq);
    if (!calm_tx && $urandom_range(99) < 22) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        req_ch.valid      = 1'b0;
        req_ch.req_type   = 2'($urandom);
        req_ch.pin_levels = 4'($urandom);
        req_ch.irq_button = 3'($urandom);
      end
    end
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.req_type   = rq;
    req_ch.pin_levels = pins;
    req_ch.irq_button = irq;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  task automatic press_button(logic [2:0] btn, int held);
    logic [3:0] own;
    own = 4'b0001 << (btn - 3'd1);
    offer_beat(REQ_TICK, pins_with(own | stray_pins()), btn);
    repeat (held) begin
      if ($urandom_range(99) < 8)
        offer_beat(pick_consume(), 4'($urandom), 3'($urandom));
      else
        offer_beat(REQ_TICK, pins_with(own | stray_pins()),
                   ($urandom_range(99) < 10) ? 3'($urandom_range(1, 4)) : BTN_NONE);
    end
    offer_beat(REQ_TICK, pins_with(stray_pins() & ~own),
               ($urandom_range(99) < 10) ? 3'($urandom_range(1, 4)) : BTN_NONE);
  endtask

  task automatic random_run(int quota);
    int first;
    first = beats_sent;
    while (beats_sent - first < quota) begin
      if ($urandom_range(99) < 15)
        offer_beat(2'($urandom), 4'($urandom), 3'($urandom));
      else
        press_button(3'($urandom_range(1, 4)), pick_hold());
      if ($urandom_range(99) < 35)
        offer_beat(pick_consume(), 4'($urandom), 3'($urandom));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reconfigure(logic [TICKS_W-1:0] ticks, logic level);
    drain();
    cfg_we    = 1'b1;
    cfg_index = CFG_LONG_PRESS_TICKS;
    cfg_data  = ticks;
    @(negedge clk);
    cfg_index = CFG_PRESSED_LEVEL;
    cfg_data  = TICKS_W'(level);
    @(negedge clk);
    cfg_we    = 1'b0;
    thr_now   = ticks;
    cur_level = level;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_LONG_PRESS_TICKS;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.pin_levels = '0;
    req_ch.irq_button = BTN_NONE;
    beats_sent        = 0;
    thr_now           = LONG_PRESS_TICKS_RST;
    cur_level         = PRESSED_LEVEL_RST;
    calm_tx           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: wait-all-released, unknown irq codes, short presses, guards
    offer_beat(REQ_TICK,       4'hF, BTN_BACK);
    offer_beat(REQ_TICK,       4'h0, 3'd7);
    offer_beat(REQ_TAKE_BACK,  4'hF, BTN_DOWN);
    offer_beat(REQ_TAKE_UI,    4'h0, BTN_NONE);
    offer_beat(REQ_DISCARD_UI, 4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, 3'd5);
    offer_beat(REQ_TICK,       4'h0, 3'd6);
    offer_beat(REQ_TICK,       4'h0, BTN_MENU);
    offer_beat(REQ_TICK,       4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_UP);
    offer_beat(REQ_TICK,       4'h0, BTN_DOWN);
    offer_beat(REQ_TAKE_BACK,  4'h0, BTN_NONE);
    offer_beat(REQ_TAKE_UI,    4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_BACK);
    offer_beat(REQ_TICK,       4'h0, BTN_NONE);
    offer_beat(REQ_TAKE_UI,    4'h0, BTN_NONE);
    offer_beat(REQ_DISCARD_UI, 4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_MENU);
    offer_beat(REQ_TAKE_BACK,  4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_DOWN);
    offer_beat(REQ_TICK,       4'h0, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_DOWN);
    offer_beat(REQ_TICK,       4'h8, BTN_NONE);
    offer_beat(REQ_TICK,       4'h0, BTN_NONE);
    random_run(100);

    // single-tick threshold, active-low pins: long presses and back guard
    reconfigure(16'd1, 1'b0);
    offer_beat(REQ_DISCARD_UI, 4'hF, BTN_NONE);
    offer_beat(REQ_TICK,       4'hB, BTN_UP);
    offer_beat(REQ_TICK,       4'hB, BTN_NONE);
    offer_beat(REQ_TICK,       4'hB, BTN_NONE);
    offer_beat(REQ_TICK,       4'hF, BTN_NONE);
    offer_beat(REQ_TICK,       4'hE, BTN_BACK);
    offer_beat(REQ_TICK,       4'hE, BTN_NONE);
    offer_beat(REQ_TICK,       4'hF, BTN_BACK);
    offer_beat(REQ_TICK,       4'hF, BTN_NONE);
    offer_beat(REQ_TAKE_BACK,  4'hF, BTN_NONE);
    random_run(250);

    reconfigure(16'd3, 1'b1);
    random_run(300);

    reconfigure(16'hFFFF, 1'b0);
    random_run(150);

    reconfigure(16'd7, 1'b1);
    calm_tx = 1'b1;
    random_run(300);
    calm_tx = 1'b0;

    reconfigure(16'd2, 1'b0);
    random_run(350);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
